FILE: hdl/sha256_message_digest_macros.svh
// Assertion macros for the SHA-256 digest block.
// Used by the top level; no other dependencies.
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/sha_pkg.sv
// Types, constants and round functions for the SHA-256 digest block.
// No dependencies.
package sha_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [31:0] word;
    logic        final_word;
  } sha_word_t;

  typedef enum logic [1:0] {F_IDLE, F_PAD_FIRST, F_PAD_REST} front_state_e;
  typedef enum logic [1:0] {B_LOAD, B_ROUND, B_UPDATE, B_EMIT} back_state_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    case (i)
      6'd0: round_k = 32'h428a2f98;   6'd1: round_k = 32'h71374491;
      6'd2: round_k = 32'hb5c0fbcf;   6'd3: round_k = 32'he9b5dba5;
      6'd4: round_k = 32'h3956c25b;   6'd5: round_k = 32'h59f111f1;
      6'd6: round_k = 32'h923f82a4;   6'd7: round_k = 32'hab1c5ed5;
      6'd8: round_k = 32'hd807aa98;   6'd9: round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

FILE: hdl/sha_if.sv
// Handshake channels of the SHA-256 digest block: byte input and digest output.
// No dependencies.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last;
  modport source (output valid, data_byte, byte_present, last, input ready);
  modport sink (input valid, data_byte, byte_present, last, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: hdl/sha_front.sv
// Front end: packs bytes into big-endian words and generates the padding words.
// Depends on sha_pkg and sha_in_if.
module sha_front import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    in_i,
  input  logic      q_full_i,
  output logic      push_o,
  output sha_word_t push_data_o
);

  front_state_e state_q, state_d;
  logic [60:0]  total_q, total_d;
  logic [31:0]  acc_q, acc_d;
  logic [3:0]   pos_q, pos_d;
  logic         len_ok_q, len_ok_d;
  logic [63:0]  bit_len;
  logic [31:0]  pad_word;
  logic [31:0]  next_acc;

  assign bit_len  = {total_q, 3'b000};
  assign next_acc = {acc_q[23:0], in_i.data_byte};

  // Partial bytes, then the marker byte, then zeros.
  always_comb begin
    case (total_q[1:0])
      2'd0: pad_word = {PAD_BYTE, 24'h0};
      2'd1: pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
      2'd2: pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
      default: pad_word = {acc_q[23:0], PAD_BYTE};
    endcase
  end

  assign in_i.ready = (state_q == F_IDLE) && !q_full_i;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    len_ok_d    = len_ok_q;
    push_o      = 1'b0;
    push_data_o = '{word: 32'h0, final_word: 1'b0};
    case (state_q)
      F_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          if (in_i.byte_present) begin
            acc_d   = next_acc;
            total_d = total_q + 61'd1;
            if (total_q[1:0] == 2'd3) begin
              push_o           = 1'b1;
              push_data_o.word = next_acc;
            end
          end
          if (in_i.last) begin
            state_d = F_PAD_FIRST;
          end
        end
      end
      F_PAD_FIRST: begin
        if (!q_full_i) begin
          push_o           = 1'b1;
          push_data_o.word = pad_word;
          pos_d            = total_q[5:2] + 4'd1;
          // The length fits in this block unless the marker lands in word 14 or 15 (from word 15 the position wraps).
          len_ok_d         = (total_q[5:2] != 4'd14);
          state_d          = F_PAD_REST;
        end
      end
      F_PAD_REST: begin
        if (!q_full_i) begin
          push_o = 1'b1;
          pos_d  = pos_q + 4'd1;
          if (len_ok_q && pos_q == 4'd14) begin
            push_data_o.word = bit_len[63:32];
          end else if (len_ok_q && pos_q == 4'd15) begin
            push_data_o.word       = bit_len[31:0];
            push_data_o.final_word = 1'b1;
            total_d                = '0;
            state_d                = F_IDLE;
          end else if (pos_q == 4'd15) begin
            len_ok_d = 1'b1;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      total_q  <= '0;
      pos_q    <= '0;
      len_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      pos_q    <= pos_d;
      len_ok_q <= len_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

FILE: hdl/sha_fifo.sv
// Short word queue between the front end and the compression engine.
// Depends on sha_pkg.
module sha_fifo import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sha_word_t push_data_i,
  input  logic      pop_i,
  output sha_word_t pop_data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  sha_word_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   count_q;

  assign full_o     = (count_q == (PtrW + 1)'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      count_q <= count_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(pop_i);
    end
  end

endmodule

FILE: hdl/sha_back.sv
// Compression engine: loads 16 words, runs 64 rounds, one per cycle, and emits the digest.
// Depends on sha_pkg and sha_out_if.
module sha_back import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  sha_word_t q_data_i,
  output logic      pop_o,
  sha_out_if.source out_o
);

  back_state_e state_q, state_d;
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] h_q [8];
  logic [31:0] h_d [8];
  logic [5:0]  cnt_q, cnt_d;
  logic [2:0]  idx_q, idx_d;
  logic        final_q, final_d;
  logic [31:0] t1, t2, w_next;

  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + round_k(cnt_q) + w_q[0];
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_next = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];

  assign out_o.valid       = (state_q == B_EMIT);
  assign out_o.digest_word = h_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    v_d     = v_q;
    h_d     = h_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    final_d = final_q;
    pop_o   = 1'b0;
    case (state_q)
      B_LOAD: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          for (int i = 0; i < 15; i++) begin
            w_d[i] = w_q[i+1];
          end
          w_d[15] = q_data_i.word;
          cnt_d   = cnt_q + 6'd1;
          if (cnt_q[3:0] == 4'd15) begin
            final_d = q_data_i.final_word;
            v_d     = h_q;
            cnt_d   = '0;
            state_d = B_ROUND;
          end
        end
      end
      B_ROUND: begin
        // The word window slides by one; the newest schedule word enters at the top.
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = w_next;
        v_d[7]  = v_q[6];
        v_d[6]  = v_q[5];
        v_d[5]  = v_q[4];
        v_d[4]  = v_q[3] + t1;
        v_d[3]  = v_q[2];
        v_d[2]  = v_q[1];
        v_d[1]  = v_q[0];
        v_d[0]  = t1 + t2;
        cnt_d   = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = B_UPDATE;
        end
      end
      B_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        cnt_d   = '0;
        idx_d   = '0;
        state_d = final_q ? B_EMIT : B_LOAD;
      end
      B_EMIT: begin
        if (out_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) begin
              h_d[i] = init_hash(3'(i));
            end
            state_d = B_LOAD;
          end
        end
      end
      default: state_d = B_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      final_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= init_hash(3'(i));
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      final_q <= final_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

endmodule

FILE: hdl/sha256_message_digest.sv
// SHA-256 digest of a byte stream, at most one byte per item.
// The front end takes one byte per cycle while not padding and the queue has room;
// the engine loads 16 words from the queue, runs 64 rounds and updates the hash per
// 64-byte block. After the last item, the front end pads out the current block,
// plus one more block when fewer than nine bytes of it are free, and the eight
// digest words follow one per cycle when taken. Reset (rst_ni low, async)
// loads the initial hash values and clears the byte count and the queue.
`include "sha256_message_digest_macros.svh"
module sha256_message_digest import sha_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);

  logic      push, pop, q_full, q_empty;
  sha_word_t push_data, pop_data;

  sha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sha_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  sha_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (pop_data),
    .pop_o     (pop),
    .out_o     (out_o)
  );

  `SHA_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push, !q_full)
  `SHA_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop, !q_empty)
  `SHA_ASSERT_NEXT(a_digest_done, clk_i, rst_ni, out_o.valid && out_o.ready && out_o.last_word, !out_o.valid)

endmodule

FILE: tb/sha256_message_digest_test.sv
// Self-checking testbench for the SHA-256 byte-stream digest block.
// Depends on sha_pkg, sha_in_if/sha_out_if and the sha256_message_digest RTL.
module sha256_message_digest_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } byte_item_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam logic [31:0] H_INIT [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sha_in_if  byte_ch ();
  sha_out_if digest_ch ();

  sha256_message_digest DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(byte_ch.sink),
                             .out_o(digest_ch.source));

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  logic [60:0] msg_bytes;

  byte_item_t   pending_bytes [$];
  digest_item_t expected_words [$];
  int  error_count = 0;
  int  digests_seen = 0;
  int  bytes_sent = 0;
  bit  hold_sender = 1'b0;
  bit  no_idle = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block(logic [7:0] blk [64]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  function automatic void predict_digest(byte_item_t it);
    logic [7:0]  pad [64];
    logic [63:0] bit_len;
    int rem;
    digest_item_t d;
    if (it.byte_present) begin
      block_bytes[msg_bytes[5:0]] = it.data_byte;
      msg_bytes = msg_bytes + 1'b1;
      if (msg_bytes[5:0] == 0) compress_block(block_bytes);
    end
    if (!it.last) return;
    rem = msg_bytes[5:0];
    for (int i = 0; i < 64; i++) pad[i] = (i < rem) ? block_bytes[i] : 8'h00;
    pad[rem] = PAD_BYTE;
    if (rem + 1 > 56) begin
      compress_block(pad);
      for (int i = 0; i < 64; i++) pad[i] = 8'h00;
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) pad[56+i] = bit_len[63-8*i -: 8];
    compress_block(pad);
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hash_state[i];
      d.word_index = i[2:0];
      d.last_word = (i == 7);
      expected_words.push_back(d);
    end
    hash_state = H_INIT;
    msg_bytes = '0;
  endfunction

  task automatic add_message(int len, bit empty_end, int fill);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      case (fill)
        0: it.data_byte = 8'h00;
        1: it.data_byte = 8'hff;
        default: it.data_byte = 8'($urandom_range(0, 255));
      endcase
      it.byte_present = 1'b1;
      it.last = (i == len - 1) && !empty_end;
      pending_bytes.push_back(it);
      // Occasional idle items inside random messages.
      if (fill > 1 && $urandom_range(0, 19) == 0) begin
        it.byte_present = 1'b0; it.last = 1'b0; it.data_byte = 8'($urandom_range(0, 255));
        pending_bytes.push_back(it);
      end
    end
    if (empty_end || len == 0) begin
      it.data_byte = 8'($urandom_range(0, 255)); it.byte_present = 1'b0; it.last = 1'b1;
      pending_bytes.push_back(it);
    end
  endtask

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data_byte <= '0;
      byte_ch.byte_present <= 1'b0;
      byte_ch.last <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        predict_digest('{byte_ch.data_byte, byte_ch.byte_present, byte_ch.last});
        bytes_sent++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (pending_bytes.size() > 0 && !hold_sender
            && (no_idle || $urandom_range(0, 99) >= 21)) begin
          byte_item_t it;
          it = pending_bytes.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.data_byte <= it.data_byte;
          byte_ch.byte_present <= it.byte_present;
          byte_ch.last <= it.last;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and sink stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digest_ch.ready <= 1'b0;
    end else begin
      if (digest_ch.valid && digest_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected digest word %h", digest_ch.digest_word);
          error_count++;
        end else begin
          digest_item_t e;
          e = expected_words.pop_front();
          if (digest_ch.digest_word !== e.digest_word) begin
            $error("digest_word expected %h actual %h", e.digest_word, digest_ch.digest_word);
            error_count++;
          end
          if (digest_ch.word_index !== e.word_index) begin
            $error("word_index expected %0d actual %0d", e.word_index, digest_ch.word_index);
            error_count++;
          end
          if (digest_ch.last_word !== e.last_word) begin
            $error("last_word expected %0b actual %0b", e.last_word, digest_ch.last_word);
            error_count++;
          end
          if (e.last_word) digests_seen++;
        end
      end
      digest_ch.ready <= no_idle || ($urandom_range(0, 99) >= 21);
    end
  end

  initial begin
    int msgs;
    hash_state = H_INIT;
    msg_bytes = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed messages: empty, one byte each extreme, 55/56/63 byte lengths
    // around the padding boundary, and an empty end right after a full block.
    add_message(0, 1'b1, 2);
    add_message(1, 1'b0, 0);
    add_message(1, 1'b0, 1);
    add_message(3, 1'b1, 2);
    add_message(55, 1'b0, 2);
    add_message(56, 1'b0, 1);
    wait (pending_bytes.size() == 0);
    // Hold the sender until every digest word has drained.
    hold_sender = 1'b1;
    wait (expected_words.size() == 0 && !byte_ch.valid);
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;
    add_message(64, 1'b1, 0);
    add_message(63, 1'b0, 2);
    wait (pending_bytes.size() == 0);
    // Random messages, mostly short, one long stretch without stalls.
    msgs = 0;
    while (msgs < 6 || (bytes_sent < 330 && msgs < 20)) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      no_idle = (msgs >= 1 && msgs < 4);
      add_message(len, ($urandom_range(0, 4) == 0), 2);
      msgs++;
      wait (pending_bytes.size() == 0);
    end
    no_idle = 1'b0;
    wait (pending_bytes.size() == 0 && !byte_ch.valid);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Hashed %0d digests over %0d input items, padding boundaries included.",
             digests_seen, bytes_sent);
    if (error_count == 0) begin
      $display("sha256_message_digest_test OK");
    end else begin
      $display("sha256_message_digest_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("sha256_message_digest_test NOT OK");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/sha_pkg.sv
hdl/sha_if.sv
hdl/sha_front.sv
hdl/sha_fifo.sv
hdl/sha_back.sv
hdl/sha256_message_digest.sv
tb/sha256_message_digest_test.sv
